@@ src/vfr_pkg.sv @@
// ----------------------------------------------------------------------------
// vfr_pkg
// Shared types and constants of the video fragment reassembler.
// ----------------------------------------------------------------------------
package vfr_pkg;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_COPY,
		ST_DRAIN,
		ST_FINAL
	} vfr_state_t;

	typedef enum logic [1:0] {
		OP_PACKET_BYTE = 2'd0,
		OP_READ_FRONT  = 2'd1,
		OP_TAKE_FRAME  = 2'd2,
		OP_TICK        = 2'd3
	} vfr_op_t;

	typedef enum logic [2:0] {
		STS_OK         = 3'd0,
		STS_FRAME_DONE = 3'd1,
		STS_SHORT      = 3'd2,
		STS_MAGIC      = 3'd3,
		STS_NO_SIZE    = 3'd4,
		STS_MISMATCH   = 3'd5,
		STS_RANGE      = 3'd6,
		STS_TOO_LONG   = 3'd7
	} vfr_status_t;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MAGIC  = 2'd2;
	localparam logic [1:0] REG_LAST   = 2'd3;

	localparam int HEADER_BYTES = 8;
	localparam logic [15:0] NO_SEQUENCE = 16'hFFFF;
	localparam logic [16:0] GATHER_LIMIT = 17'h1FFFF;

endpackage

@@ src/video_fragment_reassembler.sv @@
// ----------------------------------------------------------------------------
// video_fragment_reassembler
// Gathers video datagrams byte by byte and assembles frames in two banks.
// ----------------------------------------------------------------------------
// Usage: an operation is taken when start is high and busy is low. Every
// operation gives exactly one result, shown for one cycle with done high;
// the receiver cannot hold results off, so none is ever lost.
// Configuration goes through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high and writes are meant to happen while the block is idle.
// Flow per operation:
//   packet byte (not final), take frame, tick: result registered in the cycle after
//   acceptance, next operation accepted in the following cycle
//   read front byte: through the bank RAM read register, then ST_READ and the result register
//   final packet byte: ST_CHECK checks the header and gives the result if the check fails;
//   otherwise ST_COPY reads one payload byte per cycle from the packet store,
//   ST_DRAIN holds the last bank write and ST_FINAL closes (no payload: straight to ST_FINAL)
// The payload copy is bound by the single read port of the packet store.
// After reset the frame banks are cleared one byte a cycle, all
// 2 * MAX_FRAME_BYTES bytes; busy stays high until the pass ends, configuration
// writes are still taken.
// ----------------------------------------------------------------------------
module video_fragment_reassembler
	import vfr_pkg::*;
#(
	parameter int MAX_FRAME_BYTES  = 8192,
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [7:0]  packet_byte,
	input  logic        end_of_packet,
	input  logic [12:0] read_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  read_byte,
	output logic        frame_ready,
	output logic [31:0] frame_time_ms,
	output logic [31:0] frames_completed,
	output logic [31:0] packets_accepted
);

	localparam int BANK_DEPTH = 2 * MAX_FRAME_BYTES;
	localparam int BAW = $clog2(BANK_DEPTH);
	localparam int SAW = $clog2(MAX_PACKET_BYTES);
	localparam int PLW = $clog2(MAX_PACKET_BYTES + 1);
	localparam int FSW = $clog2(MAX_FRAME_BYTES + 1);

	vfr_state_t state_q, state_d;

	// configuration
	logic [15:0] width_q, height_q;
	logic [7:0]  magic_q, last_mask_q;
	logic [31:0] prod_q;

	// packet side
	logic [PLW-1:0] pkt_len_q;
	logic           overflow_q;
	logic [7:0]     hdr_q [HEADER_BYTES];
	logic [PLW-1:0] rd_ptr_q;
	logic [BAW-1:0] wr_ptr_q;
	logic           wr_valid_s1;
	logic [BAW-1:0] wr_addr_s1;

	// frame side
	logic           front_q;
	logic [15:0]    cur_seq_q;
	logic [16:0]    gathered_q;
	logic           ready_q;
	logic [31:0]    ms_q, comp_time_q, frame_cnt_q, frag_cnt_q;
	logic           rd_ok_q;
	logic [BAW-1:0] clr_addr_q;

	// result registers
	logic       done_q;
	logic [2:0] status_q;
	logic [7:0] read_byte_q;
	logic       ready_out_q;

	// RAM ports
	logic           st_we;
	logic [SAW-1:0] st_waddr, st_raddr;
	logic [7:0]     st_rdata;
	logic           bk_we;
	logic [BAW-1:0] bk_waddr, bk_raddr;
	logic [7:0]     bk_wdata, bk_rdata;

	// combinational control
	logic        accept;
	logic        emit;
	vfr_status_t status_d;
	logic [33:0] fs_full;
	logic [FSW-1:0] fs;
	logic [15:0] hdr_seq, hdr_total, hdr_offset;
	logic [PLW-1:0] payload;
	logic [17:0] gather_sum;
	logic [16:0] gathered_new;
	logic        seq_load, range_bad, is_last;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign fs_full = {2'b00, prod_q} + {1'b0, prod_q, 1'b0};
	assign fs = (fs_full > 34'(MAX_FRAME_BYTES)) ? '0 : fs_full[FSW-1:0];

	assign hdr_seq    = {hdr_q[2], hdr_q[3]};
	assign hdr_total  = {hdr_q[4], hdr_q[5]};
	assign hdr_offset = {hdr_q[6], hdr_q[7]};
	assign payload    = pkt_len_q - PLW'(HEADER_BYTES);

	assign gather_sum   = {1'b0, gathered_q} + 18'(payload);
	assign gathered_new = (gather_sum > {1'b0, GATHER_LIMIT}) ? GATHER_LIMIT
		: gather_sum[16:0];
	assign is_last = ((hdr_q[1] & last_mask_q) != 8'd0) && (32'(gathered_new) >= 32'(fs));
	assign range_bad = (32'(hdr_offset) + 32'(payload)) > 32'(fs);
	assign seq_load  = (hdr_seq != cur_seq_q);

	// packet store: write while bytes arrive, read during the copy
	assign st_we    = accept && (operation == OP_PACKET_BYTE)
		&& (32'(pkt_len_q) < MAX_PACKET_BYTES);
	assign st_waddr = pkt_len_q[SAW-1:0];
	assign st_raddr = rd_ptr_q[SAW-1:0];

	// frame banks: clearing pass, or payload writes in the cycle after the store read
	assign bk_we    = (state_q == ST_CLEAR) || wr_valid_s1;
	assign bk_waddr = (state_q == ST_CLEAR) ? clr_addr_q : wr_addr_s1;
	assign bk_wdata = (state_q == ST_CLEAR) ? 8'd0 : st_rdata;
	assign bk_raddr = front_q ? BAW'(32'(read_index) + MAX_FRAME_BYTES)
		: BAW'(32'(read_index));

	vfr_ram #(.WIDTH(8), .DEPTH(MAX_PACKET_BYTES)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (packet_byte),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	vfr_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_banks (
		.clk   (clk),
		.we    (bk_we),
		.waddr (bk_waddr),
		.wdata (bk_wdata),
		.raddr (bk_raddr),
		.rdata (bk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		emit     = 1'b0;
		status_d = STS_OK;
		unique case (state_q)
			ST_CLEAR: begin
				if (32'(clr_addr_q) == BANK_DEPTH - 1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (operation)
						OP_PACKET_BYTE: begin
							if (end_of_packet) begin
								state_d = ST_CHECK;
							end else begin
								emit = 1'b1;
							end
						end
						OP_READ_FRONT: state_d = ST_READ;
						OP_TAKE_FRAME, OP_TICK: emit = 1'b1;
						default: emit = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				emit    = 1'b1;
				state_d = ST_IDLE;
			end
			ST_CHECK: begin
				state_d = ST_IDLE;
				emit    = 1'b1;
				priority if (overflow_q) begin
					status_d = STS_TOO_LONG;
				end else if (32'(pkt_len_q) < HEADER_BYTES) begin
					status_d = STS_SHORT;
				end else if (hdr_q[0] != magic_q) begin
					status_d = STS_MAGIC;
				end else if (fs == '0) begin
					status_d = STS_NO_SIZE;
				end else if (32'(hdr_total) != 32'(fs)) begin
					status_d = STS_MISMATCH;
				end else if (range_bad) begin
					status_d = STS_RANGE;
				end else if (payload == '0) begin
					emit    = 1'b0;
					state_d = ST_FINAL;
				end else begin
					emit    = 1'b0;
					state_d = ST_COPY;
				end
			end
			ST_COPY: begin
				if (rd_ptr_q == pkt_len_q - PLW'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_FINAL;
			ST_FINAL: begin
				emit     = 1'b1;
				status_d = is_last ? STS_FRAME_DONE : STS_OK;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= '0;
			height_q    <= '0;
			magic_q     <= '0;
			last_mask_q <= 8'd1;
			prod_q      <= '0;
			pkt_len_q   <= '0;
			overflow_q  <= 1'b0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			wr_valid_s1 <= 1'b0;
			wr_addr_s1  <= '0;
			front_q     <= 1'b0;
			cur_seq_q   <= NO_SEQUENCE;
			gathered_q  <= '0;
			ready_q     <= 1'b0;
			ms_q        <= '0;
			comp_time_q <= '0;
			frame_cnt_q <= '0;
			frag_cnt_q  <= '0;
			rd_ok_q     <= 1'b0;
			clr_addr_q  <= '0;
			done_q      <= 1'b0;
			status_q    <= '0;
			read_byte_q <= '0;
			ready_out_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				priority if (cfg_index == 8'(REG_WIDTH)) begin
					width_q <= cfg_data;
				end else if (cfg_index == 8'(REG_HEIGHT)) begin
					height_q <= cfg_data;
				end else if (cfg_index == 8'(REG_MAGIC)) begin
					magic_q <= cfg_data[7:0];
				end else if (cfg_index == 8'(REG_LAST)) begin
					last_mask_q <= cfg_data[7:0];
				end
			end
			prod_q <= width_q * height_q;

			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + BAW'(1);
			end

			wr_valid_s1 <= (state_q == ST_COPY);
			wr_addr_s1  <= wr_ptr_q;

			done_q <= emit;
			if (emit) begin
				status_q    <= status_d;
				read_byte_q <= (state_q == ST_READ && rd_ok_q) ? bk_rdata : 8'd0;
				// a completing fragment shows the flag it has just set
				ready_out_q <= ready_q || (state_q == ST_FINAL && is_last);
			end

			if (accept) begin
				unique case (operation)
					OP_PACKET_BYTE: begin
						if (32'(pkt_len_q) < MAX_PACKET_BYTES) begin
							pkt_len_q <= pkt_len_q + PLW'(1);
						end else begin
							overflow_q <= 1'b1;
						end
					end
					OP_READ_FRONT: rd_ok_q <= (32'(read_index) < MAX_FRAME_BYTES);
					OP_TAKE_FRAME: ready_q <= 1'b0;
					OP_TICK:       ms_q <= ms_q + 32'd1;
					default: ;
				endcase
			end

			if (state_q == ST_CHECK) begin
				rd_ptr_q <= PLW'(HEADER_BYTES);
				wr_ptr_q <= front_q ? BAW'(32'(hdr_offset))
					: BAW'(32'(hdr_offset) + MAX_FRAME_BYTES);
				if (!overflow_q && 32'(pkt_len_q) >= HEADER_BYTES && hdr_q[0] == magic_q
					&& fs != '0 && 32'(hdr_total) == 32'(fs) && seq_load) begin
					cur_seq_q  <= hdr_seq;
					gathered_q <= '0;
				end
				if (emit) begin
					pkt_len_q  <= '0;
					overflow_q <= 1'b0;
				end
			end

			if (state_q == ST_COPY) begin
				rd_ptr_q <= rd_ptr_q + PLW'(1);
				wr_ptr_q <= wr_ptr_q + BAW'(1);
			end

			if (state_q == ST_FINAL) begin
				pkt_len_q  <= '0;
				overflow_q <= 1'b0;
				frag_cnt_q <= frag_cnt_q + 32'd1;
				if (is_last) begin
					front_q     <= ~front_q;
					ready_q     <= 1'b1;
					comp_time_q <= ms_q;
					frame_cnt_q <= frame_cnt_q + 32'd1;
					cur_seq_q   <= NO_SEQUENCE;
					gathered_q  <= '0;
				end else begin
					gathered_q <= gathered_new;
				end
			end
		end
	end

	// header bytes are kept in flops as they arrive
	always_ff @(posedge clk) begin
		if (accept && operation == OP_PACKET_BYTE && 32'(pkt_len_q) < HEADER_BYTES) begin
			hdr_q[pkt_len_q[2:0]] <= packet_byte;
		end
	end

	assign done             = done_q;
	assign status           = status_q;
	assign read_byte        = read_byte_q;
	assign frame_ready      = ready_out_q;
	assign frame_time_ms    = comp_time_q;
	assign frames_completed = frame_cnt_q;
	assign packets_accepted = frag_cnt_q;

endmodule

@@ src/vfr_ram.sv @@
// ----------------------------------------------------------------------------
// vfr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module vfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ verif/video_fragment_reassembler_test.sv @@
// ----------------------------------------------------------------------------
// video_fragment_reassembler_test
// Self-checking bench for the video fragment reassembler. A short table of
// directed operations is followed by random datagram traffic: mostly
// well-formed frames cut into fragments, mixed with broken datagrams, reads,
// takes and ticks. Every result is compared with a built-in predictor.
// ----------------------------------------------------------------------------
module video_fragment_reassembler_test;
	import vfr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_MAX  = 8192;
	localparam int PACKET_MAX = 2048;
	localparam int STALL_LIMIT = 80000;

	typedef struct packed {
		vfr_status_t status;
		logic [7:0]  read_byte;
		logic        frame_ready;
		logic [31:0] frame_time_ms;
		logic [31:0] frames_completed;
		logic [31:0] packets_accepted;
	} vfr_result_t;

	typedef struct {
		vfr_op_t     op;
		logic [7:0]  pbyte;
		logic        eop;
		logic [12:0] idx;
		vfr_status_t st;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [7:0]  packet_byte;
	logic        end_of_packet;
	logic [12:0] read_index;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        done;
	logic [2:0]  status;
	logic [7:0]  read_byte;
	logic        frame_ready;
	logic [31:0] frame_time_ms;
	logic [31:0] frames_completed;
	logic [31:0] packets_accepted;

	video_fragment_reassembler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .packet_byte(packet_byte),
		.end_of_packet(end_of_packet), .read_index(read_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .status(status), .read_byte(read_byte),
		.frame_ready(frame_ready), .frame_time_ms(frame_time_ms),
		.frames_completed(frames_completed), .packets_accepted(packets_accepted)
	);

	// predictor state
	logic [15:0] cfg_w, cfg_h;
	logic [7:0]  cfg_magic, cfg_mask;
	logic [7:0]  pkt_store [0:PACKET_MAX-1];
	int          pkt_len;
	bit          pkt_over;
	logic [7:0]  bank_mem [0:2*FRAME_MAX-1];
	bit          front_sel;
	logic [15:0] cur_seq;
	int          gathered;
	bit          frame_pending;
	logic [31:0] done_time, ms_count, frame_cnt, frag_cnt;

	vfr_result_t pending_results [$];
	int          errors;
	int          item_count;
	int          idle_pct;
	int          stall_cycles = 0;

	function automatic int frame_size();
		longint n;
		n = longint'(cfg_w) * longint'(cfg_h) * 3;
		return (n > FRAME_MAX) ? 0 : int'(n);
	endfunction

	function automatic vfr_result_t apply_operation(vfr_op_t op, logic [7:0] pbyte,
			logic eop, logic [12:0] idx);
		vfr_result_t r;
		int fs, total, offset, payload;
		logic [15:0] seq;
		logic [7:0] flags;
		r = '0;
		r.status = STS_OK;
		case (op)
			OP_PACKET_BYTE: begin
				if (pkt_len < PACKET_MAX) begin
					pkt_store[pkt_len] = pbyte;
					pkt_len++;
				end else
					pkt_over = 1;
				if (eop) begin
					fs = frame_size();
					flags = pkt_store[1];
					seq = {pkt_store[2], pkt_store[3]};
					total = {pkt_store[4], pkt_store[5]};
					offset = {pkt_store[6], pkt_store[7]};
					if (pkt_over)
						r.status = STS_TOO_LONG;
					else if (pkt_len < HEADER_BYTES)
						r.status = STS_SHORT;
					else if (pkt_store[0] != cfg_magic)
						r.status = STS_MAGIC;
					else if (fs == 0)
						r.status = STS_NO_SIZE;
					else if (total != fs)
						r.status = STS_MISMATCH;
					else begin
						// a new sequence restarts the count even when the range check fails
						if (seq != cur_seq) begin
							cur_seq = seq;
							gathered = 0;
						end
						payload = pkt_len - HEADER_BYTES;
						if (offset + payload > fs)
							r.status = STS_RANGE;
						else begin
							for (int i = 0; i < payload; i++)
								bank_mem[(front_sel ? 0 : FRAME_MAX) + offset + i] =
									pkt_store[HEADER_BYTES + i];
							gathered = (gathered + payload > int'(GATHER_LIMIT)) ?
								int'(GATHER_LIMIT) : gathered + payload;
							frag_cnt++;
							if ((flags & cfg_mask) != 0 && gathered >= fs) begin
								front_sel = !front_sel;
								frame_pending = 1;
								done_time = ms_count;
								frame_cnt++;
								cur_seq = NO_SEQUENCE;
								gathered = 0;
								r.status = STS_FRAME_DONE;
							end
						end
					end
					pkt_len = 0;
					pkt_over = 0;
				end
				r.frame_ready = frame_pending;
			end
			OP_READ_FRONT: begin
				r.read_byte = bank_mem[(front_sel ? FRAME_MAX : 0) + idx];
				r.frame_ready = frame_pending;
			end
			OP_TAKE_FRAME: begin
				r.frame_ready = frame_pending;
				frame_pending = 0;
			end
			default: begin
				ms_count++;
				r.frame_ready = frame_pending;
			end
		endcase
		r.frame_time_ms = done_time;
		r.frames_completed = frame_cnt;
		r.packets_accepted = frag_cnt;
		return r;
	endfunction

	task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// drive one transaction and log its expected result once accepted
	task automatic run_item(vfr_op_t op, logic [7:0] pbyte, logic eop, logic [12:0] idx,
			output vfr_result_t pred);
		@(negedge clk);
		start <= 1'b1;
		operation <= op;
		packet_byte <= pbyte;
		end_of_packet <= eop;
		read_index <= idx;
		do @(posedge clk); while (busy);
		pred = apply_operation(op, pbyte, eop, idx);
		pending_results.push_back(pred);
		item_count++;
		if ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0 || busy)
			@(negedge clk);
		// some margin before touching the registers
		repeat (6) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= 8'(idx);
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WIDTH:  cfg_w = value;
			REG_HEIGHT: cfg_h = value;
			REG_MAGIC:  cfg_magic = value[7:0];
			default:    cfg_mask = value[7:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(logic [15:0] w, logic [15:0] h, logic [7:0] m, logic [7:0] k);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_MAGIC, 16'(m));
		write_reg(REG_LAST, 16'(k));
	endtask

	task automatic send_datagram(logic [7:0] magic, logic [7:0] flags, logic [15:0] seq,
			logic [15:0] total, logic [15:0] offset, int plen, int nbytes);
		logic [7:0] bytes [$];
		vfr_result_t p;
		bytes = {magic, flags, seq[15:8], seq[7:0], total[15:8], total[7:0],
			offset[15:8], offset[7:0]};
		for (int i = 0; i < plen; i++)
			bytes.push_back(8'($urandom));
		while (bytes.size() < nbytes)
			bytes.push_back(8'($urandom));
		for (int i = 0; i < nbytes; i++)
			run_item(OP_PACKET_BYTE, bytes[i], i == nbytes - 1, 13'($urandom), p);
	endtask

	task automatic send_side_op();
		vfr_result_t p;
		int fs;
		fs = frame_size();
		case ($urandom_range(2))
			0: run_item(OP_READ_FRONT, 8'($urandom), 1'($urandom),
				(fs > 0 && $urandom_range(9) < 7) ? 13'($urandom_range(fs - 1)) :
				13'($urandom), p);
			1: run_item(OP_TAKE_FRAME, 8'($urandom), 1'($urandom), 13'($urandom), p);
			default: run_item(OP_TICK, 8'($urandom), 1'($urandom), 13'($urandom), p);
		endcase
	endtask

	task automatic send_frame(int max_chunk);
		int fs, off, chunk, n;
		int order [$];
		int sizes [$];
		logic [15:0] seq;
		logic [7:0] flags;
		fs = frame_size();
		seq = 16'($urandom);
		if (fs == 0) begin
			send_datagram(cfg_magic, 8'($urandom), seq, 16'(cfg_w * cfg_h * 3), 0, 3, 11);
			return;
		end
		off = 0;
		while (off < fs) begin
			chunk = $urandom_range(1, (fs - off < max_chunk) ? fs - off : max_chunk);
			order.push_back(off);
			sizes.push_back(chunk);
			off += chunk;
		end
		n = order.size();
		// sometimes swap the first two fragments so offsets do not arrive in order
		if (n > 2 && $urandom_range(3) == 0) begin
			off = order[0]; order[0] = order[1]; order[1] = off;
			chunk = sizes[0]; sizes[0] = sizes[1]; sizes[1] = chunk;
		end
		for (int i = 0; i < n; i++) begin
			flags = (i == n - 1) ? (8'($urandom) | cfg_mask) : (8'($urandom) & ~cfg_mask);
			send_datagram(cfg_magic, flags, seq, 16'(fs), 16'(order[i]), sizes[i],
				HEADER_BYTES + sizes[i]);
			if ($urandom_range(9) == 0)
				send_side_op();
		end
	endtask

	task automatic send_broken();
		int fs, plen;
		vfr_result_t p;
		fs = frame_size();
		plen = $urandom_range(1, 6);
		case ($urandom_range(5))
			0: send_datagram(cfg_magic ^ 8'(1 << $urandom_range(7)), 8'($urandom),
				16'($urandom), 16'(fs), 0, plen, HEADER_BYTES + plen);
			1: send_datagram(cfg_magic, 8'($urandom), 16'($urandom), 16'(fs + 1), 0,
				plen, HEADER_BYTES + plen);
			2: send_datagram(cfg_magic, 8'($urandom), 16'($urandom), 16'(fs),
				16'(fs - plen + $urandom_range(1, 3)), plen, HEADER_BYTES + plen);
			3: send_datagram(cfg_magic, 8'($urandom), 16'($urandom), 16'(fs), 0, 0,
				$urandom_range(1, HEADER_BYTES - 1));
			4: send_datagram(cfg_magic, 8'($urandom), 16'($urandom), 16'(fs), 0, 0,
				HEADER_BYTES);
			default: begin
				plen = $urandom_range(1, 10);
				for (int i = 0; i < plen; i++)
					run_item(OP_PACKET_BYTE, 8'($urandom), i == plen - 1, 13'($urandom), p);
			end
		endcase
	endtask

	stim_row_t directed [] = '{
		'{OP_READ_FRONT,  8'h00, 1'b0, 13'd0,    STS_OK},
		'{OP_READ_FRONT,  8'hFF, 1'b1, 13'd8191, STS_OK},
		'{OP_TICK,        8'hFF, 1'b1, 13'd8191, STS_OK},
		'{OP_TAKE_FRAME,  8'h00, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'h00, 1'b0, 13'd8191, STS_OK},
		'{OP_PACKET_BYTE, 8'hFF, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'h12, 1'b1, 13'd0,    STS_SHORT},
		'{OP_PACKET_BYTE, 8'h00, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'h01, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'h00, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'h07, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'h00, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'h03, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'h00, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'h00, 1'b1, 13'd0,    STS_NO_SIZE},
		'{OP_PACKET_BYTE, 8'h55, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'h80, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'hFF, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'hFF, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'h00, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'h03, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'h00, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'h00, 1'b0, 13'd0,    STS_OK},
		'{OP_PACKET_BYTE, 8'hAA, 1'b1, 13'd0,    STS_MAGIC}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0)
				flag_mismatch("result with none expected", status, 0);
			else begin
				vfr_result_t e;
				e = pending_results.pop_front();
				if (status != e.status) flag_mismatch("status", status, e.status);
				if (read_byte != e.read_byte) flag_mismatch("read_byte", read_byte, e.read_byte);
				if (frame_ready != e.frame_ready)
					flag_mismatch("frame_ready", frame_ready, e.frame_ready);
				if (frame_time_ms != e.frame_time_ms)
					flag_mismatch("frame_time_ms", frame_time_ms, e.frame_time_ms);
				if (frames_completed != e.frames_completed)
					flag_mismatch("frames_completed", frames_completed, e.frames_completed);
				if (packets_accepted != e.packets_accepted)
					flag_mismatch("packets_accepted", packets_accepted, e.packets_accepted);
			end
		end
	end

	// ends the run when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("video_fragment_reassembler_test NOT OK");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		vfr_result_t p;
		int fs;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_TICK;
		packet_byte = '0;
		end_of_packet = 1'b0;
		read_index = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		item_count = 0;
		idle_pct = 14;
		cfg_w = 0; cfg_h = 0; cfg_magic = 0; cfg_mask = 8'd1;
		pkt_len = 0; pkt_over = 0; front_sel = 0; cur_seq = NO_SEQUENCE;
		gathered = 0; frame_pending = 0;
		done_time = 0; ms_count = 0; frame_cnt = 0; frag_cnt = 0;
		foreach (pkt_store[i]) pkt_store[i] = '0;
		foreach (bank_mem[i]) bank_mem[i] = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			run_item(directed[i].op, directed[i].pbyte, directed[i].eop, directed[i].idx, p);
			if (p.status != directed[i].st)
				flag_mismatch("directed status", p.status, directed[i].st);
		end

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 14 : (ph == 1) ? 84 : 0;
			for (int sub = 0; sub < 4; sub++) begin
				case (sub)
					0: set_config(16'hFFFF, 16'hFFFF, 8'hFF, 8'h00);
					1: set_config(16'd1, 16'd1, 8'h00, 8'hFF);
					default: set_config(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
						8'($urandom), 8'($urandom_range(1, 255)));
				endcase
				fs = item_count;
				while (item_count - fs < 90) begin
					case ($urandom_range(9))
						0, 1: send_broken();
						2: send_side_op();
						default: send_frame(16);
					endcase
				end
			end
		end

		// largest frame size that still fits, and reads near the top of the bank
		set_config(16'd2730, 16'd1, 8'h5A, 8'h81);
		run_item(OP_READ_FRONT, 8'h00, 1'b0, 13'd8189, p);
		run_item(OP_READ_FRONT, 8'h00, 1'b0, 13'd8191, p);
		run_item(OP_TAKE_FRAME, 8'h00, 1'b0, 13'd0, p);
		for (int i = 0; i < 20; i++)
			send_side_op();

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("video_fragment_reassembler_test OK");
		else
			$display("video_fragment_reassembler_test NOT OK");
		$finish;
	end

endmodule
